/* hdl/tsb_pkg.sv */
// ----------------------------------------------------------------------------
// Texture span blender package
// Shared types, codes and helper functions of the texture span blender.
// ----------------------------------------------------------------------------
package tsb_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_SPAN  = 2'd1,
		OP_PIXEL = 2'd2
	} op_t;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_SPAN  = 2'd1;
	localparam logic [1:0] KIND_PIXEL = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	localparam logic [1:0] BM_TEXTURE = 2'd0;
	localparam logic [1:0] BM_OVER    = 2'd1;
	localparam logic [1:0] BM_FOG     = 2'd2;

	localparam logic [2:0] CFG_WIDTH_LOG2  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT_LOG2 = 3'd1;
	localparam logic [2:0] CFG_LEVEL_COUNT = 3'd2;
	localparam logic [2:0] CFG_BLEND_MODE  = 3'd3;
	localparam logic [2:0] CFG_MOD_COLOR   = 3'd4;

	localparam logic [31:0] STEP_LIMIT = 32'd124518;
	localparam logic [3:0]  MAX_LOG2   = 4'd12;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		op_t         op;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
	} q_entry_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	function automatic logic [31:0] half_signed(input logic [31:0] x);
		return {x[31], x[31:1]};
	endfunction

	function automatic logic [3:0] level_bits(input logic [3:0] log2v, input logic [3:0] lvl);
		logic [3:0] b;
		b = (log2v > MAX_LOG2) ? MAX_LOG2 : log2v;
		return (b > lvl) ? (b - lvl) : 4'd0;
	endfunction

endpackage

/* hdl/texture_span_blender.sv */
// ----------------------------------------------------------------------------
// Texture span blender
// Affine texture mapper with mip level select and destination blend.
// ----------------------------------------------------------------------------
// A pixel result passes the queue, the texture read register and the result register.
// One item per cycle unless the queue fills or results stall; a span start holds the back end
// in a level search. Loads use the texture write port and pixels the texture read port.
// Reset clears control state and sets the registers to their defaults at once.
// The texture memory is not cleared and holds undefined data until loaded.
module texture_span_blender
	import tsb_pkg::*;
#(
	parameter int TEX_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [11:0] load_address,
	input  logic [31:0] load_texel,
	input  logic [31:0] u_start,
	input  logic [31:0] v_start,
	input  logic [31:0] u_step,
	input  logic [31:0] v_step,
	input  logic [31:0] dst_pixel,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] out_pixel,
	output logic [11:0] texel_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic     q_push;
	logic     q_pop;
	logic     q_valid;
	logic     q_full;
	q_entry_t q_in;
	q_entry_t q_head;
	cfg_wr_t  cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

	tsb_front u_front (
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.kind        (kind),
		.load_address(load_address),
		.load_texel  (load_texel),
		.u_start     (u_start),
		.v_start     (v_start),
		.u_step      (u_step),
		.v_step      (v_step),
		.dst_pixel   (dst_pixel),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	tsb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.valid    (q_valid),
		.full     (q_full),
		.head     (q_head)
	);

	tsb_back #(
		.TEX_DEPTH(TEX_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_pixel   (out_pixel),
		.texel_index (texel_index)
	);

endmodule

/* hdl/tsb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/tsb_front.sv */
// ----------------------------------------------------------------------------
// Texture span blender front end
// Accepts items, drops unused kinds and packs the rest into queue entries.
// ----------------------------------------------------------------------------
module tsb_front
	import tsb_pkg::*;
(
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [11:0] load_address,
	input  logic [31:0] load_texel,
	input  logic [31:0] u_start,
	input  logic [31:0] v_start,
	input  logic [31:0] u_step,
	input  logic [31:0] v_step,
	input  logic [31:0] dst_pixel,
	input  logic        q_full,
	output logic        q_push,
	output q_entry_t    q_data
);

	logic keep;

	always_comb begin
		keep   = 1'b1;
		q_data = '{op: OP_PIXEL, w0: dst_pixel, w1: '0, w2: '0, w3: '0};
		unique case (kind)
			KIND_LOAD: begin
				q_data = '{op: OP_LOAD, w0: {20'd0, load_address}, w1: load_texel,
					w2: '0, w3: '0};
			end
			KIND_SPAN: begin
				q_data = '{op: OP_SPAN, w0: u_start, w1: v_start, w2: u_step, w3: v_step};
			end
			KIND_PIXEL: begin
				q_data = '{op: OP_PIXEL, w0: dst_pixel, w1: '0, w2: '0, w3: '0};
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full && keep;

endmodule

/* hdl/tsb_queue.sv */
// ----------------------------------------------------------------------------
// Texture span blender queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tsb_queue
	import tsb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	input  logic     pop,
	output logic     valid,
	output logic     full,
	output q_entry_t head
);

	q_entry_t          buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign valid = (count_q != '0);
	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue count exceeds its depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("item pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("item popped from an empty queue");
`endif

endmodule

/* hdl/tsb_back.sv */
// ----------------------------------------------------------------------------
// Texture span blender back end
// Runs loads, mip level search and pixel fetch and blend from queue entries.
// ----------------------------------------------------------------------------
module tsb_back
	import tsb_pkg::*;
#(
	parameter int TEX_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_wr_t     cfg_wr,
	input  logic        q_valid,
	input  q_entry_t    q_head,
	output logic        q_pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] out_pixel,
	output logic [11:0] texel_index
);

	localparam int AW = $clog2(TEX_DEPTH);

	logic [3:0]  width_log2_q;
	logic [3:0]  height_log2_q;
	logic [3:0]  level_count_q;
	logic [1:0]  blend_mode_q;
	logic [31:0] mod_color_q;

	state_t      state_q;
	state_t      state_d;
	logic [31:0] u_q;
	logic [31:0] v_q;
	logic [31:0] du_q;
	logic [31:0] dv_q;
	logic [3:0]  lvl_q;
	logic [AW-1:0] base_q;

	logic          adv;
	logic          span_pop;
	logic          load_pop;
	logic          pix_issue;
	logic          search_go;
	logic          search_step;
	logic [3:0]    last_lvl;
	logic [3:0]    lvl_wb;
	logic [3:0]    lvl_hb;
	logic [4:0]    size_log2;
	logic [AW-1:0] level_size;

	logic [3:0]    xb;
	logic [3:0]    yb;
	logic [4:0]    vshift;
	logic [31:0]   vmask;
	logic [31:0]   umask;
	logic [31:0]   offset;
	logic [AW-1:0] fetch_addr;

	logic          v_s1;
	logic [31:0]   dst_s1;
	logic [11:0]   idx_s1;
	logic [31:0]   texel;
	logic [31:0]   blend;

	logic          v_s2;
	logic [31:0]   pix_s2;
	logic [11:0]   idx_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= 4'd6;
			height_log2_q <= 4'd6;
			level_count_q <= 4'd1;
			blend_mode_q  <= BM_TEXTURE;
			mod_color_q   <= ALL_ONES;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				CFG_WIDTH_LOG2:  width_log2_q  <= cfg_wr.data[3:0];
				CFG_HEIGHT_LOG2: height_log2_q <= cfg_wr.data[3:0];
				CFG_LEVEL_COUNT: level_count_q <= cfg_wr.data[3:0];
				CFG_BLEND_MODE:  blend_mode_q  <= cfg_wr.data[1:0];
				CFG_MOD_COLOR:   mod_color_q   <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// Issue control.
	assign adv       = !v_s2 || !result_stall;
	assign last_lvl  = (level_count_q == 4'd0) ? 4'd0 : (level_count_q - 4'd1);
	assign search_go = ((mag32(du_q) > STEP_LIMIT) || (mag32(dv_q) > STEP_LIMIT))
		&& (lvl_q < last_lvl);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (span_pop) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!search_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop       = 1'b0;
		search_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_pop = q_valid && ((q_head.op != OP_PIXEL) || adv);
			end
			ST_SEARCH: begin
				search_step = search_go;
			end
			default: ;
		endcase
	end

	assign span_pop  = q_pop && (q_head.op == OP_SPAN);
	assign load_pop  = q_pop && (q_head.op == OP_LOAD);
	assign pix_issue = q_pop && (q_head.op == OP_PIXEL);

	// Size of the level that the search steps past, wrapped to the store.
	assign lvl_wb     = level_bits(width_log2_q, lvl_q);
	assign lvl_hb     = level_bits(height_log2_q, lvl_q);
	assign size_log2  = {1'b0, lvl_wb} + {1'b0, lvl_hb};
	assign level_size = (32'(size_log2) < AW) ? (AW'(1) << size_log2) : '0;

	// Texel address of the current pixel.
	assign xb         = level_bits(width_log2_q, lvl_q);
	assign yb         = level_bits(height_log2_q, lvl_q);
	assign vshift     = 5'd16 - {1'b0, xb};
	assign umask      = (32'd1 << xb) - 32'd1;
	assign vmask      = ((32'd1 << yb) - 32'd1) << xb;
	assign offset     = ((v_q >> vshift) & vmask) + ({16'd0, u_q[31:16]} & umask);
	assign fetch_addr = base_q + offset[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			u_q     <= '0;
			v_q     <= '0;
			du_q    <= '0;
			dv_q    <= '0;
			lvl_q   <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			if (span_pop) begin
				u_q    <= q_head.w0;
				v_q    <= q_head.w1;
				du_q   <= q_head.w2;
				dv_q   <= q_head.w3;
				lvl_q  <= '0;
				base_q <= '0;
			end else if (search_step) begin
				u_q    <= half_signed(u_q);
				v_q    <= half_signed(v_q);
				du_q   <= half_signed(du_q);
				dv_q   <= half_signed(dv_q);
				lvl_q  <= lvl_q + 4'd1;
				base_q <= base_q + level_size;
			end else if (pix_issue) begin
				u_q <= u_q + du_q;
				v_q <= v_q + dv_q;
			end
		end
	end

	tsb_ram #(
		.WIDTH(32),
		.DEPTH(TEX_DEPTH)
	) u_tex_ram (
		.clk    (clk),
		.wr_en  (load_pop),
		.wr_addr(AW'(q_head.w0[11:0])),
		.wr_data(q_head.w1),
		.rd_en  (pix_issue),
		.rd_addr(fetch_addr),
		.rd_data(texel)
	);

	// Blend stage.
	always_comb begin
		logic [16:0] m257;
		logic [15:0] mhalf;
		logic [16:0] a257;
		logic [15:0] ahalf;
		logic [24:0] prod;
		logic [10:0] sum;
		logic [7:0]  fog;
		blend = '0;
		m257  = '0;
		mhalf = '0;
		prod  = '0;
		sum   = '0;
		a257  = 17'(texel[31:24]) * 17'd257;
		ahalf = a257[16:1];
		fog   = 8'hFF - texel[23:16];
		unique case (blend_mode_q)
			BM_TEXTURE: begin
				if (mod_color_q == ALL_ONES) begin
					blend = texel;
				end else begin
					for (int k = 0; k < 4; k++) begin
						m257  = 17'(mod_color_q[8*k +: 8]) * 17'd257;
						mhalf = m257[16:1];
						prod  = 25'({texel[8*k +: 8], 1'b0}) * 25'(mhalf);
						blend[8*k +: 8] = prod[23:16];
					end
				end
			end
			BM_OVER: begin
				for (int k = 0; k < 4; k++) begin
					prod = 25'({dst_s1[8*k +: 8], 1'b0}) * 25'(ahalf);
					sum  = 11'(texel[8*k +: 8]) + 11'(dst_s1[8*k +: 8]) - 11'(prod[23:16]);
					if (sum[10]) begin
						blend[8*k +: 8] = 8'd0;
					end else if (sum > 11'd255) begin
						blend[8*k +: 8] = 8'hFF;
					end else begin
						blend[8*k +: 8] = sum[7:0];
					end
				end
			end
			BM_FOG: begin
				blend = (dst_s1 < {24'd0, fog}) ? dst_s1 : {24'd0, fog};
			end
			default: begin
				blend = dst_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_issue) begin
			dst_s1 <= q_head.w0;
			idx_s1 <= 12'(fetch_addr);
		end
		if (adv && v_s1) begin
			pix_s2 <= blend;
			idx_s2 <= idx_s1;
		end
	end

	assign result_valid = v_s2;
	assign out_pixel    = pix_s2;
	assign texel_index  = idx_s2;

`ifndef SYNTHESIS
	a_search_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !q_pop)
		else $error("item taken from the queue during a level search");
	a_issue_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		pix_issue |=> v_s1)
		else $error("issued pixel did not reach the blend stage");
	a_stage_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(dst_s1) && $stable(idx_s1)))
		else $error("blend stage changed while the result was stalled");
`endif

endmodule

/* bench/tsb_checker.sv */
// ----------------------------------------------------------------------------
// Texture span blender checker
// Watches the item, result and register channels of the blender, keeps its
// own copy of the texture, span state and registers, predicts each blended
// pixel and compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module tsb_checker
	import tsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  kind,
	input  logic [11:0] load_address,
	input  logic [31:0] load_texel,
	input  logic [31:0] u_start,
	input  logic [31:0] v_start,
	input  logic [31:0] u_step,
	input  logic [31:0] v_step,
	input  logic [31:0] dst_pixel,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [31:0] out_pixel,
	input  logic [11:0] texel_index,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [31:0] pixel;
		logic [11:0] index;
	} shaded_t;

	localparam int TEXEL_WORDS = 4096;

	logic [31:0] texels [TEXEL_WORDS];
	logic [31:0] u_pos, v_pos, u_inc, v_inc;
	logic [3:0]  mip;
	logic [11:0] mip_base;
	logic [3:0]  reg_width, reg_height, reg_levels;
	logic [1:0]  reg_mode;
	logic [31:0] reg_modulate;
	shaded_t     queued_pixels [$];

	function automatic logic [31:0] magnitude(input logic [31:0] x);
		return x[31] ? 32'd0 - x : x;
	endfunction

	function automatic int dim_bits(input logic [3:0] log2v, input logic [3:0] level);
		int b;
		b = (log2v > MAX_LOG2) ? int'(MAX_LOG2) : int'(log2v);
		return (b > int'(level)) ? b - int'(level) : 0;
	endfunction

	task automatic start_span(input logic [31:0] u, input logic [31:0] v,
			input logic [31:0] du, input logic [31:0] dv);
		logic [3:0]  last;
		logic [3:0]  level;
		logic [31:0] base;
		last = (reg_levels == 4'd0) ? 4'd0 : reg_levels - 4'd1;
		level = 4'd0;
		base = 32'd0;
		while ((magnitude(du) > STEP_LIMIT || magnitude(dv) > STEP_LIMIT) && level < last) begin
			base += 32'd1 << (dim_bits(reg_width, level) + dim_bits(reg_height, level));
			du = $signed(du) >>> 1;
			dv = $signed(dv) >>> 1;
			u = $signed(u) >>> 1;
			v = $signed(v) >>> 1;
			level++;
		end
		u_pos = u;
		v_pos = v;
		u_inc = du;
		v_inc = dv;
		mip = level;
		mip_base = base[11:0];
	endtask

	task automatic shade_pixel(input logic [31:0] dst);
		int          xb, yb, alpha, dc, sum, m;
		logic [31:0] umask, vmask, offset, texel, blended, fog;
		logic [11:0] addr;
		shaded_t     pending;
		xb = dim_bits(reg_width, mip);
		yb = dim_bits(reg_height, mip);
		umask = (32'd1 << xb) - 32'd1;
		vmask = ((32'd1 << yb) - 32'd1) << xb;
		offset = ((v_pos >> (16 - xb)) & vmask) + ((u_pos >> 16) & umask);
		addr = mip_base + offset[11:0];
		texel = texels[addr];
		u_pos += u_inc;
		v_pos += v_inc;
		blended = 32'd0;
		case (reg_mode)
			BM_TEXTURE: begin
				if (reg_modulate == ALL_ONES) begin
					blended = texel;
				end else begin
					for (int k = 0; k < 4; k++) begin
						m = (257 * int'(reg_modulate[8*k +: 8])) >> 1;
						blended[8*k +: 8] = 8'(((2 * int'(texel[8*k +: 8])) * m) >> 16);
					end
				end
			end
			BM_OVER: begin
				alpha = (257 * int'(texel[31:24])) >> 1;
				for (int k = 0; k < 4; k++) begin
					dc = int'(dst[8*k +: 8]);
					sum = int'(texel[8*k +: 8]) + dc - (((2 * dc) * alpha) >> 16);
					if (sum < 0) sum = 0;
					if (sum > 255) sum = 255;
					blended[8*k +: 8] = sum[7:0];
				end
			end
			BM_FOG: begin
				fog = 32'd255 - {24'd0, texel[23:16]};
				blended = (dst < fog) ? dst : fog;
			end
			default: begin
				blended = dst;
			end
		endcase
		pending.pixel = blended;
		pending.index = addr;
		queued_pixels = {queued_pixels, pending};
	endtask

	always @(posedge clk or negedge arst_n) begin
		shaded_t want;
		if (!arst_n) begin
			u_pos = 32'd0;
			v_pos = 32'd0;
			u_inc = 32'd0;
			v_inc = 32'd0;
			mip = 4'd0;
			mip_base = 12'd0;
			reg_width = 4'd6;
			reg_height = 4'd6;
			reg_levels = 4'd1;
			reg_mode = BM_TEXTURE;
			reg_modulate = ALL_ONES;
			queued_pixels.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (queued_pixels.size() == 0) begin
					$error("unexpected result: out_pixel %h, texel_index %h", out_pixel,
						texel_index);
					mismatches++;
				end else begin
					want = queued_pixels.pop_front();
					if (out_pixel !== want.pixel) begin
						$error("out_pixel: expected %h, actual %h", want.pixel, out_pixel);
						mismatches++;
					end
					if (texel_index !== want.index) begin
						$error("texel_index: expected %h, actual %h", want.index, texel_index);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				case (kind)
					KIND_LOAD:  texels[load_address] = load_texel;
					KIND_SPAN:  start_span(u_start, v_start, u_step, v_step);
					KIND_PIXEL: shade_pixel(dst_pixel);
					default:    ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WIDTH_LOG2:  reg_width = cfg_data[3:0];
					CFG_HEIGHT_LOG2: reg_height = cfg_data[3:0];
					CFG_LEVEL_COUNT: reg_levels = cfg_data[3:0];
					CFG_BLEND_MODE:  reg_mode = cfg_data[1:0];
					CFG_MOD_COLOR:   reg_modulate = cfg_data;
					default:         ;
				endcase
			end
			outstanding = queued_pixels.size();
		end
	end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Texture span blender testbench
// Fills the low part of the texture store, runs a short directed sequence and
// then random phases of span starts, pixels, loads and unused kinds under
// several register settings and stall patterns, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
	import tsb_pkg::*;

	localparam logic [1:0] KIND_SPARE  = 2'd3;
	localparam logic [1:0] BM_SPARE    = 2'd3;
	localparam int         HALF_PERIOD = 6;
	localparam int         RESET_CYCLES = 9;
	localparam int         TEXEL_WORDS = 4096;
	localparam int         FILL_WORDS  = 384;
	localparam int         FOOTPRINT_LOG2 = 7;
	localparam int         PHASES      = 12;
	localparam int         PHASE_ITEMS = 90;
	localparam int         SETTLE      = 100;
	localparam int         HOLD_CYCLES = 80;
	localparam int         WATCH_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  kind = KIND_LOAD;
	logic [11:0] load_address = 12'd0;
	logic [31:0] load_texel = 32'd0;
	logic [31:0] u_start = 32'd0;
	logic [31:0] v_start = 32'd0;
	logic [31:0] u_step = 32'd0;
	logic [31:0] v_step = 32'd0;
	logic [31:0] dst_pixel = 32'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [31:0] out_pixel;
	logic [11:0] texel_index;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_WIDTH_LOG2;
	logic [31:0] cfg_data = 32'd0;

	int fails;
	int outstanding;
	int send_idle = 31;
	int recv_idle = 58;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet = 0;

	always #HALF_PERIOD clk = ~clk;

	texture_span_blender #(.TEX_DEPTH(TEXEL_WORDS)) dut (.*);

	tsb_checker chk (
		.clk, .arst_n, .item_valid, .item_stall, .kind, .load_address, .load_texel,
		.u_start, .v_start, .u_step, .v_step, .dst_pixel, .result_valid, .result_stall,
		.out_pixel, .texel_index, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.mismatches(fails), .outstanding(outstanding)
	);

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet + 1 >= WATCH_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send(input logic [1:0] k, input logic [11:0] addr, input logic [31:0] tx,
			input logic [31:0] us, input logic [31:0] vs, input logic [31:0] du,
			input logic [31:0] dv, input logic [31:0] dst);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		load_address <= addr;
		load_texel <= tx;
		u_start <= us;
		v_start <= vs;
		u_step <= du;
		v_step <= dv;
		dst_pixel <= dst;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_load(input logic [11:0] addr, input logic [31:0] tx);
		send(KIND_LOAD, addr, tx, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_span(input logic [31:0] us, input logic [31:0] vs,
			input logic [31:0] du, input logic [31:0] dv);
		send(KIND_SPAN, 12'($urandom), $urandom, us, vs, du, dv, $urandom);
	endtask

	task automatic send_pixel(input logic [31:0] dst);
		send(KIND_PIXEL, 12'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, dst);
	endtask

	task automatic send_spare();
		send(KIND_SPARE, 12'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [3:0] w, input logic [3:0] h, input logic [3:0] levels,
			input logic [1:0] mode, input logic [31:0] modulate);
		write_reg(CFG_WIDTH_LOG2, {28'd0, w});
		write_reg(CFG_HEIGHT_LOG2, {28'd0, h});
		write_reg(CFG_LEVEL_COUNT, {28'd0, levels});
		write_reg(CFG_BLEND_MODE, {30'd0, mode});
		write_reg(CFG_MOD_COLOR, modulate);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_step();
		logic [31:0] s;
		case ($urandom_range(0, 9))
			0:       s = STEP_LIMIT;
			1:       s = STEP_LIMIT + 32'd1;
			default: s = $urandom >> $urandom_range(0, 31);
		endcase
		return $urandom_range(0, 1) ? 32'd0 - s : s;
	endfunction

	// Width plus height within seven bits keeps every level of every span
	// inside the filled words of the texture store.
	function automatic logic [7:0] rand_dims();
		logic [3:0] w;
		w = 4'($urandom_range(0, FOOTPRINT_LOG2));
		return {w, 4'($urandom_range(0, FOOTPRINT_LOG2 - int'(w)))};
	endfunction

	task automatic run_phase(input int count);
		int done;
		int pick;
		done = 0;
		send_span($urandom, $urandom, rand_step(), rand_step());
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_spare();
			end else begin
				if (pick < 9)
					send_load(12'($urandom), $urandom);
				else if (pick < 22)
					send_span($urandom, $urandom, rand_step(), rand_step());
				else if ($urandom_range(0, 3) == 0)
					send_pixel($urandom_range(0, 300));
				else
					send_pixel($urandom);
				done++;
			end
		end
	endtask

	initial begin
		logic [7:0] dims;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < FILL_WORDS; i++)
			send_load(i[11:0], $urandom);
		settle();

		configure(4'd4, 4'd3, 4'd13, BM_OVER, ALL_ONES);
		send_load(12'd0, ALL_ONES);
		send_load(12'hFFF, 32'd0);
		send_span(32'd0, 32'd0, 32'd0, 32'd0);
		send_pixel(32'd0);
		send_pixel(ALL_ONES);
		send_span(32'h7FFF_FFFF, 32'h8000_0000, STEP_LIMIT, 32'd0 - STEP_LIMIT);
		send_pixel(32'h8080_8080);
		send_span(32'h8000_0000, 32'h7FFF_FFFF, STEP_LIMIT + 32'd1, 32'd0);
		send_pixel(ALL_ONES);
		send_pixel(32'd0);
		send_span(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0 - STEP_LIMIT - 32'd1);
		send_pixel($urandom);
		send_span($urandom, $urandom, 32'h8000_0000, 32'h7FFF_FFFF);
		send_pixel($urandom);
		send_pixel($urandom);
		send_pixel($urandom);
		send_spare();
		send_pixel(32'h00FF_00FF);
		settle();

		// Oversized widths and heights, with coordinates that stay in filled words.
		configure(4'd13, 4'd0, 4'd2, BM_TEXTURE, ALL_ONES);
		send_span(32'h100A_0000, 32'h7FFF_0000, STEP_LIMIT + 32'd1, 32'd0);
		repeat (4) send_pixel($urandom);
		settle();
		configure(4'd15, 4'd15, 4'd1, BM_FOG, ALL_ONES);
		send_span(32'h0010_0000, $urandom, 32'h0001_0000, 32'd0);
		repeat (4) send_pixel($urandom);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 4) begin
				send_idle = 58;
				recv_idle = 31;
			end else if (p == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			dims = rand_dims();
			case (p)
				0: configure(4'd0, 4'd0, 4'd0, BM_TEXTURE, ALL_ONES);
				1: configure(4'd7, 4'd0, 4'd13, BM_OVER, $urandom);
				2: configure(4'd0, 4'd7, 4'd15, BM_FOG, ALL_ONES);
				3: configure(4'd3, 4'd4, 4'd1, BM_SPARE, 32'd0);
				4: configure(dims[7:4], dims[3:0], 4'($urandom), BM_TEXTURE, 32'd0);
				5: configure(dims[7:4], dims[3:0], 4'($urandom), BM_TEXTURE, $urandom);
				default: configure(dims[7:4], dims[3:0], 4'($urandom), 2'($urandom),
					$urandom_range(0, 3) == 0 ? ALL_ONES : $urandom);
			endcase
			if (p == 9) begin
				send_pixel($urandom);
				hold_req = 1'b1;
			end
			run_phase(PHASE_ITEMS);
			settle();
		end

		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
